FILE: rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam logic [3:0] OPCODE_MASK   = 4'hF;
    localparam logic [3:0] OPCODE_BINARY = 4'h2;
    localparam logic [6:0] LEN_CODE_16   = 7'h7E;
    localparam logic [6:0] LEN_CODE_64   = 7'h7F;
    localparam logic [3:0] EXT_BYTES_16  = 4'd2;
    localparam logic [3:0] EXT_BYTES_64  = 4'd8;
    localparam logic [3:0] KEY_BYTES     = 4'd4;

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DEAD    = 3'd5;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_OPCODE  = 2'd1;
    localparam logic [1:0] KIND_NOMASK  = 2'd2;
    localparam logic [1:0] KIND_ZEROLEN = 2'd3;

    typedef struct packed {
        logic [2:0]  phase;
        logic [6:0]  len_code;
        logic [3:0]  hdr_cnt;
        logic [63:0] remaining;
        logic [31:0] key;
        logic [1:0]  key_idx;
    } state_t;

    typedef struct packed {
        logic       has;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

FILE: rtl/wsd_step.sv
// ----------------------------------------------------------------------------
// wsd_step
// Next-state and result logic for one stream byte.
// ----------------------------------------------------------------------------
module wsd_step (
    input  wsd_pkg::state_t  st,
    input  logic [7:0]       stream_byte,
    output wsd_pkg::state_t  st_next,
    output wsd_pkg::result_t res
);
    import wsd_pkg::*;

    logic [3:0]  cnt_inc;
    logic [3:0]  ext_need;
    logic [63:0] rem_dec;
    logic [7:0]  key_byte;

    assign cnt_inc  = st.hdr_cnt + 4'd1;
    assign ext_need = (st.len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
    assign rem_dec  = st.remaining - 64'd1;

    always_comb
    begin
        case (st.key_idx)
            2'd0:    key_byte = st.key[31:24];
            2'd1:    key_byte = st.key[23:16];
            2'd2:    key_byte = st.key[15:8];
            default: key_byte = st.key[7:0];
        endcase
    end

    always_comb
    begin
        st_next = st;
        res     = '0;
        case (st.phase)
            PH_FIRST:
            begin
                if ((stream_byte[3:0] & OPCODE_MASK) != OPCODE_BINARY)
                begin
                    st_next.phase = PH_DEAD;
                    res.has       = 1'b1;
                    res.kind      = KIND_OPCODE;
                end
                else
                begin
                    st_next.phase = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (!stream_byte[7])
                begin
                    st_next.phase = PH_DEAD;
                    res.has       = 1'b1;
                    res.kind      = KIND_NOMASK;
                end
                else
                begin
                    st_next.len_code = stream_byte[6:0];
                    st_next.hdr_cnt  = '0;
                    if (stream_byte[6:0] inside {LEN_CODE_16, LEN_CODE_64})
                    begin
                        st_next.remaining = '0;
                        st_next.phase     = PH_EXTLEN;
                    end
                    else
                    begin
                        st_next.remaining = {57'd0, stream_byte[6:0]};
                        st_next.phase     = PH_KEY;
                    end
                end
            end
            PH_EXTLEN:
            begin
                st_next.remaining = {st.remaining[55:0], stream_byte};
                st_next.hdr_cnt   = cnt_inc;
                if (cnt_inc >= ext_need)
                begin
                    st_next.hdr_cnt = '0;
                    st_next.phase   = PH_KEY;
                end
            end
            PH_KEY:
            begin
                st_next.key     = {st.key[23:0], stream_byte};
                st_next.hdr_cnt = cnt_inc;
                if (cnt_inc >= KEY_BYTES)
                begin
                    st_next.hdr_cnt = '0;
                    st_next.key_idx = '0;
                    if (st.remaining == 64'd0)
                    begin
                        st_next.phase = PH_DEAD;
                        res.has       = 1'b1;
                        res.kind      = KIND_ZEROLEN;
                    end
                    else
                    begin
                        st_next.phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res.has  = 1'b1;
                res.kind = KIND_DATA;
                res.data = stream_byte ^ key_byte;
                res.last = (rem_dec == 64'd0);
                st_next.key_idx   = st.key_idx + 2'd1;
                st_next.remaining = rem_dec;
                if (rem_dec == 64'd0)
                begin
                    st_next = '0;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

FILE: rtl/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Client-to-server WebSocket deframer: parses frame headers, unmasks payload
// bytes and reports protocol errors.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid, in_stall, stream_byte          | in
//   out     | out_valid, out_stall, kind,              | out
//           | payload_byte, frame_last                 |
//
// One byte per cycle while the output is not stalled; a byte passes the input
// register, then the result register. Header bytes retire even while the
// output is stalled; a result-producing byte waits for the result register.
// Asynchronous reset clears the parser state and both valid flags.
// After an error result the block takes and drops every byte until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] stream_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic       frame_last
);
    import wsd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    state_t     st_reg;
    state_t     st_next;
    result_t    res;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       out_free;
    logic       advance;

    wsd_step u_step (
        .st          (st_reg),
        .stream_byte (in_byte_reg),
        .st_next     (st_next),
        .res         (res)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!res.has || out_free);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && res.has;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= stream_byte;
        end
        if (out_free && advance && res.has)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            last_reg <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = data_reg;
    assign frame_last   = last_reg;

endmodule

FILE: rtl/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level assertions for the WebSocket deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] payload_byte,
    input logic       frame_last
);
    import wsd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(payload_byte)
                                   && $stable(frame_last))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> payload_byte == 8'd0 && !frame_last)
        else $error("error item carries data");

    a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind != KIND_DATA |=> !out_valid)
        else $error("item after error");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_last   (frame_last)
);
